// ----- hdl/tbjh_pkg.sv -----
// Shared types, constants and helpers for the threshold-binning joint histogram.
package tbjh_pkg;

  localparam int NUM_CODES   = 16;
  localparam int NUM_BINS    = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int NUM_EDGES   = 7;

  localparam int CODE_W      = $clog2(NUM_CODES);
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int ADDR_W      = CODE_W + BIN_W;
  localparam int JOINT_DEPTH = NUM_CODES * (1 << BIN_W);

  localparam int VALUE_W   = 16;
  localparam int FIELD_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = CFG_IDX_W'(NUM_EDGES);

  localparam logic [VALUE_W-1:0] EDGE_RESET = 16'h7FFF;
  localparam logic [3:0]         BINS_RESET = 4'd8;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

// ----- hdl/threshold_bin_joint_histogram.sv -----
// Threshold-binning joint histogram: bins samples and keeps joint, class, bin and total counts.
//
// Usage:
//   The slave stream carries one word per item. tuser is the kind: add a sample
//   or read the counts for a class code and bin. The master stream returns one
//   result word per item: the bin, the joint count, the class count, the bin
//   count and the sample total, each taken after the item's own update.
//   Bin edges and the number of bins in use are written through the cfg port
//   while no items are in flight.
// Timing:
//   An accepted word goes through an input stage (bin search and joint count
//   RAM read) and an update stage (saturating increments), then the output
//   register. One word is taken per cycle while m_tready keeps the output free.
//   A same-entry update in consecutive cycles is forwarded from the last RAM
//   write, so back-to-back samples keep the full rate.
// Reset and stalls:
//   Synchronous reset clears all counts at once (the joint count RAM is masked
//   by per-entry valid bits) and restores the edge and bin registers. When the
//   receiver holds tready low, the stages fill up and tready on the slave side
//   drops only once all three are occupied.
module threshold_bin_joint_histogram (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [tbjh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbjh_pkg::CFG_W-1:0]      cfg_data,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,  // sample_value, class_code, read_bin
  input  logic                            s_tuser,  // kind
  // Result stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // bin_index, joint_count, class_total, bin_total, sample_total
  output logic [71:0]                     m_tdata
);

  localparam int CW = tbjh_pkg::COUNT_WIDTH;
  localparam int FW = tbjh_pkg::FIELD_W;

  // Configuration registers.
  logic signed [tbjh_pkg::VALUE_W-1:0] edge_val [tbjh_pkg::NUM_EDGES];
  logic [3:0]                          bins_in_use;

  // Input stage.
  logic                                a_valid;
  tbjh_pkg::kind_t                     a_kind;
  logic signed [tbjh_pkg::VALUE_W-1:0] a_value;
  logic [3:0]                          a_code;
  logic [2:0]                          a_rbin;
  logic [3:0]                          bins_n;
  logic [3:0]                          last_bin;
  logic [3:0]                          a_pick;
  logic [2:0]                          a_bin;
  logic                                a_bin_ok;
  logic                                a_code_ok;
  logic [tbjh_pkg::ADDR_W-1:0]         a_addr;

  // Update stage.
  logic                                b_valid;
  tbjh_pkg::kind_t                     b_kind;
  logic [2:0]                          b_bin;
  logic                                b_bin_ok;
  logic                                b_code_ok;
  logic [tbjh_pkg::ADDR_W-1:0]         b_addr;
  logic [tbjh_pkg::CODE_W-1:0]         b_code_idx;
  logic [tbjh_pkg::BIN_W-1:0]          b_bin_idx;
  logic                                b_count;
  logic [CW-1:0]                       joint_old;
  logic [CW-1:0]                       joint_res;
  logic [CW-1:0]                       class_res;
  logic [CW-1:0]                       bin_res;
  logic [CW-1:0]                       total_res;

  // Count storage.
  logic [CW-1:0]                       class_cnt [tbjh_pkg::NUM_CODES];
  logic [CW-1:0]                       bin_cnt [tbjh_pkg::NUM_BINS];
  logic [CW-1:0]                       total_samples;
  logic [tbjh_pkg::JOINT_DEPTH-1:0]    joint_valid;
  logic [CW-1:0]                       ram_q;
  logic                                ram_we;
  logic                                lastwr_valid;
  logic [tbjh_pkg::ADDR_W-1:0]         lastwr_addr;
  logic [CW-1:0]                       lastwr_data;
  logic                                fwd;

  // Output register.
  logic [2:0]                          m_bin;
  logic [FW-1:0]                       m_joint;
  logic [FW-1:0]                       m_class;
  logic [FW-1:0]                       m_bintot;
  logic [FW-1:0]                       m_total;

  // Handshake.
  logic out_free;
  logic b_go;
  logic b_load;
  logic s_acc;

  assign out_free = !m_tvalid || m_tready;
  assign b_go     = b_valid && out_free;
  assign b_load   = a_valid && (!b_valid || b_go);
  assign s_tready = !a_valid || b_load;
  assign s_acc    = s_tvalid && s_tready;

  assign m_tdata = {5'd0, m_total, m_bintot, m_class, m_joint, m_bin};

  // Bin search: the first used edge that is not below the sample, else the last bin.
  always_comb begin
    bins_n = bins_in_use;
    if (bins_n == 4'd0) begin
      bins_n = 4'd1;
    end else if (bins_n > 4'(tbjh_pkg::NUM_BINS)) begin
      bins_n = 4'(tbjh_pkg::NUM_BINS);
    end
    last_bin = bins_n - 4'd1;
    a_pick   = last_bin;
    for (int b = tbjh_pkg::NUM_EDGES - 1; b >= 0; b--) begin
      if ((4'(b) < last_bin) && (a_value <= edge_val[b])) begin
        a_pick = 4'(b);
      end
    end
    a_bin     = (a_kind == tbjh_pkg::KIND_READ) ? a_rbin : 3'(a_pick);
    a_bin_ok  = int'(a_bin) < tbjh_pkg::NUM_BINS;
    a_code_ok = int'(a_code) < tbjh_pkg::NUM_CODES;
    a_addr    = {tbjh_pkg::CODE_W'(a_code), tbjh_pkg::BIN_W'(a_bin)};
  end

  tbjh_ram #(
    .WIDTH(CW),
    .DEPTH(tbjh_pkg::JOINT_DEPTH)
  ) u_joint_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(b_addr),
    .wdata(joint_res),
    .re   (b_load),
    .raddr(a_addr),
    .rdata(ram_q)
  );

  // The RAM read misses only the write made at the same edge; the last write
  // register always matches memory for its address, so it can be forwarded.
  always_comb begin
    b_code_idx = b_addr[tbjh_pkg::ADDR_W-1:tbjh_pkg::BIN_W];
    b_bin_idx  = b_addr[tbjh_pkg::BIN_W-1:0];
    fwd        = lastwr_valid && (lastwr_addr == b_addr);
    if (fwd) begin
      joint_old = lastwr_data;
    end else if (joint_valid[b_addr]) begin
      joint_old = ram_q;
    end else begin
      joint_old = '0;
    end
    b_count = b_valid && (b_kind == tbjh_pkg::KIND_ADD) && b_code_ok;

    if (b_code_ok && b_bin_ok) begin
      joint_res = b_count ? tbjh_pkg::sat_inc(joint_old) : joint_old;
    end else begin
      joint_res = '0;
    end
    if (b_code_ok) begin
      class_res = b_count ? tbjh_pkg::sat_inc(class_cnt[b_code_idx]) : class_cnt[b_code_idx];
    end else begin
      class_res = '0;
    end
    if (b_bin_ok) begin
      bin_res = b_count ? tbjh_pkg::sat_inc(bin_cnt[b_bin_idx]) : bin_cnt[b_bin_idx];
    end else begin
      bin_res = '0;
    end
    total_res = b_count ? tbjh_pkg::sat_inc(total_samples) : total_samples;
    ram_we    = b_go && b_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tbjh_pkg::NUM_EDGES; i++) begin
        edge_val[i] <= tbjh_pkg::EDGE_RESET;
      end
      bins_in_use   <= tbjh_pkg::BINS_RESET;
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      m_tvalid      <= 1'b0;
      lastwr_valid  <= 1'b0;
      joint_valid   <= '0;
      total_samples <= '0;
      for (int i = 0; i < tbjh_pkg::NUM_CODES; i++) begin
        class_cnt[i] <= '0;
      end
      for (int i = 0; i < tbjh_pkg::NUM_BINS; i++) begin
        bin_cnt[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        priority if (int'(cfg_index) < tbjh_pkg::NUM_EDGES) begin
          edge_val[cfg_index] <= cfg_data;
        end else if (cfg_index == tbjh_pkg::CFG_BINS_IN_USE) begin
          bins_in_use <= cfg_data[3:0];
        end
      end

      if (s_acc) begin
        a_valid <= 1'b1;
      end else if (b_load) begin
        a_valid <= 1'b0;
      end
      if (b_load) begin
        b_valid <= 1'b1;
      end else if (b_go) begin
        b_valid <= 1'b0;
      end
      if (b_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (ram_we) begin
        lastwr_valid           <= 1'b1;
        joint_valid[b_addr]    <= 1'b1;
        class_cnt[b_code_idx]  <= class_res;
        bin_cnt[b_bin_idx]     <= bin_res;
        total_samples          <= total_res;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      a_kind  <= tbjh_pkg::kind_t'(s_tuser);
      a_value <= s_tdata[15:0];
      a_code  <= s_tdata[19:16];
      a_rbin  <= s_tdata[22:20];
    end
    if (b_load) begin
      b_kind    <= a_kind;
      b_bin     <= a_bin;
      b_bin_ok  <= a_bin_ok;
      b_code_ok <= a_code_ok;
      b_addr    <= a_addr;
    end
    if (ram_we) begin
      lastwr_addr <= b_addr;
      lastwr_data <= joint_res;
    end
    if (b_go) begin
      m_bin    <= b_bin;
      m_joint  <= FW'(joint_res);
      m_class  <= FW'(class_res);
      m_bintot <= FW'(bin_res);
      m_total  <= FW'(total_res);
    end
  end

`ifndef SYNTHESIS
  // A joint count never exceeds its class or bin count, and those never exceed the total.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_joint <= m_class) && (m_joint <= m_bintot) &&
                 (m_class <= m_total) && (m_bintot <= m_total))
    else $error("result counts are inconsistent");

  // The sample total only grows between resets.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (total_samples >= $past(total_samples)))
    else $error("sample total decreased");

  // A stalled update stage keeps its item and does not write the joint counts.
  assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_go) |=> b_valid && $stable(b_addr) && !$past(ram_we))
    else $error("stalled update stage lost its item");
`endif

endmodule

// ----- hdl/tbjh_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module tbjh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
